>>> rtl/catmull_rom_point_eval_defines.svh
// Assertion macros for the RTL file that checks its own logic.
`ifndef CATMULL_ROM_POINT_EVAL_DEFINES_SVH
`define CATMULL_ROM_POINT_EVAL_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property outside reset.
`define CRPE_ASSERT(name, prop) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("crpe assertion failed");

// Check a property at every edge, reset included.
`define CRPE_ASSERT_RST(name, prop) \
    name: assert property (@(posedge i_clk) prop) \
        else $error("crpe reset assertion failed");

`else

`define CRPE_ASSERT(name, prop)
`define CRPE_ASSERT_RST(name, prop)

`endif

`endif

>>> rtl/crpe_pkg.sv
package crpe_pkg;

    // Store and field geometry
    localparam int MAX_POINTS = 64;
    localparam int FRAC_BITS  = 12;
    localparam int T_W        = 18;
    localparam int SEG_W      = T_W - FRAC_BITS;
    localparam int PT_W       = 16;
    localparam int PIDX_W     = 6;
    localparam int CNT_W      = 7;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int NUM_TAPS   = 4;

    // Datapath widths
    localparam int F2_W    = 2 * FRAC_BITS;
    localparam int F3_W    = 3 * FRAC_BITS;
    localparam int Q_W     = F3_W + 4;
    localparam int W_W     = 2 * FRAC_BITS + 3;
    localparam int PROD_W  = PT_W + W_W;
    localparam int ACC_W   = PROD_W + 2;
    localparam int OUT_SH  = 2 * FRAC_BITS + 1;
    localparam int SUM_W   = ACC_W - OUT_SH;
    localparam int N_STG   = 5;

    // Rounding and saturation constants
    localparam logic signed [Q_W-1:0]   ONE_Q   = Q_W'(1) << F3_W;
    localparam logic signed [Q_W-1:0]   W_RND   = Q_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] OUT_RND = ACC_W'(1) << (2 * FRAC_BITS);
    localparam logic signed [SUM_W-1:0] SAT_HI  = SUM_W'(2 ** (PT_W - 1) - 1);
    localparam logic signed [SUM_W-1:0] SAT_LO  = SUM_W'(-(2 ** (PT_W - 1)));

    // Configuration port
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_LOOPED_MODE = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_POINT_COUNT = 1'd1;
    localparam logic [CNT_W-1:0]     COUNT_RESET     = 7'd2;

    // Commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    // Chosen store addresses for one evaluation
    typedef struct packed {
        logic [NUM_TAPS-1:0][ADDR_W-1:0] idx;
        logic                            err;
    } t_idx_sel;

endpackage

>>> rtl/crpe_ram.sv
module crpe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read two entries, hold the data while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

>>> rtl/crpe_index_sel.sv
module crpe_index_sel (
    input  logic                        i_looped,
    input  logic [crpe_pkg::CNT_W-1:0]  i_count,
    input  logic [crpe_pkg::SEG_W-1:0]  i_seg,
    output crpe_pkg::t_idx_sel          o_sel
);
    import crpe_pkg::*;

    logic [CNT_W-1:0] w_n;
    logic [CNT_W-1:0] w_seg;
    logic [CNT_W-1:0] w_seg1;
    logic [CNT_W-1:0] w_c0;
    logic [CNT_W-1:0] w_c2;
    logic [CNT_W-1:0] w_c3;

    // Limit the count to the store size
    assign w_n    = (i_count > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : i_count;
    assign w_seg  = CNT_W'(i_seg);
    assign w_seg1 = w_seg + CNT_W'(1);

    // Clamped neighbors; with seg below n, seg+1 wraps only when it reaches n
    assign w_c0 = (w_seg == '0) ? '0 : w_seg - CNT_W'(1);
    assign w_c2 = (w_seg1 == w_n) ? '0 : w_seg1;
    assign w_c3 = (w_c2 == w_n - CNT_W'(1)) ? w_c2 : w_c2 + CNT_W'(1);

    // Pick addresses and range check for the mode
    always_comb begin
        if (i_looped) begin
            o_sel.idx[0] = ADDR_W'(w_seg);
            o_sel.idx[1] = ADDR_W'(w_seg + CNT_W'(1));
            o_sel.idx[2] = ADDR_W'(w_seg + CNT_W'(2));
            o_sel.idx[3] = ADDR_W'(w_seg + CNT_W'(3));
            o_sel.err    = (w_n == '0) || ((w_seg + CNT_W'(3)) >= w_n);
        end else begin
            o_sel.idx[0] = ADDR_W'(w_c0);
            o_sel.idx[1] = ADDR_W'(w_seg);
            o_sel.idx[2] = ADDR_W'(w_c2);
            o_sel.idx[3] = ADDR_W'(w_c3);
            o_sel.err    = (w_n == '0) || (w_seg >= w_n);
        end
    end

endmodule

>>> rtl/catmull_rom_point_eval.sv
// Uniform Catmull-Rom point evaluator. A write transaction (cmd 0) stores one
// Q8.8 control point; an evaluate transaction (cmd 1) blends four neighbor
// points at the fraction of t_param and returns one rounded, saturated result,
// or zero with index_error set when a chosen index is at or past the point
// count. One transaction is taken every cycle unless the output stalls.
// A result leaves five register stages after its transaction: store read and
// f^2, f^3, weights, products, sum and saturation. The four store reads per
// cycle come from two copies of the point store, each with two read ports. A
// point written in one cycle is seen by an evaluation taken in the next. The
// store has no reset; evaluating a never-written point gives an unspecified
// value. Write the configuration registers (looped_mode at 0x0, point_count at
// 0x4) only while no result is pending.
`include "catmull_rom_point_eval_defines.svh"

module catmull_rom_point_eval (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_cmd,
    input  logic [crpe_pkg::PIDX_W-1:0]   i_point_index,
    input  logic signed [crpe_pkg::PT_W-1:0] i_point_x,
    input  logic signed [crpe_pkg::PT_W-1:0] i_point_y,
    input  logic [crpe_pkg::T_W-1:0]      i_t_param,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [crpe_pkg::PT_W-1:0] o_out_x,
    output logic signed [crpe_pkg::PT_W-1:0] o_out_y,
    output logic                          o_index_error,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [crpe_pkg::PADDR_W-1:0]  paddr,
    input  logic [crpe_pkg::PDATA_W-1:0]  pwdata,
    output logic [crpe_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import crpe_pkg::*;

    // Configuration registers
    logic             r_looped;
    logic [CNT_W-1:0] r_count;
    logic [REG_IDX_W-1:0] w_reg_idx;
    logic             w_cfg_wr;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[PADDR_W-1:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_looped <= 1'b0;
            r_count  <= COUNT_RESET;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_LOOPED_MODE: r_looped <= pwdata[0];
                REG_POINT_COUNT: r_count  <= pwdata[CNT_W-1:0];
                default:         r_looped <= r_looped;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_LOOPED_MODE: prdata = PDATA_W'(r_looped);
            REG_POINT_COUNT: prdata = PDATA_W'(r_count);
            default:         prdata = '0;
        endcase
    end

    // Stage valids and per-stage ready chain
    logic [N_STG-1:0] r_v;
    logic [N_STG-1:0] w_rdy;

    always_comb begin
        w_rdy[N_STG-1] = !r_v[N_STG-1] || i_out_ready;
        for (int k = N_STG - 2; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    logic w_acc;
    logic w_eval;
    logic w_wr;

    assign o_in_ready = w_rdy[0];
    assign w_acc      = i_in_valid && o_in_ready;
    assign w_eval     = w_acc && (i_cmd == CMD_EVAL);
    assign w_wr       = w_acc && (i_cmd == CMD_WRITE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= w_eval;
            end
            for (int k = 1; k < N_STG; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Index selection from the segment part
    logic [SEG_W-1:0]     w_seg;
    logic [FRAC_BITS-1:0] w_f;
    t_idx_sel             w_sel;

    assign w_seg = i_t_param[T_W-1:FRAC_BITS];
    assign w_f   = i_t_param[FRAC_BITS-1:0];

    crpe_index_sel u_index_sel (
        .i_looped (r_looped),
        .i_count  (r_count),
        .i_seg    (w_seg),
        .o_sel    (w_sel)
    );

    // Point store, two copies for four reads a cycle
    logic [2*PT_W-1:0] w_wdata;
    logic [2*PT_W-1:0] w_rd [NUM_TAPS];

    assign w_wdata = {i_point_y, i_point_x};

    crpe_ram #(.WIDTH(2 * PT_W), .DEPTH(MAX_POINTS)) u_ram_lo (
        .i_clk     (i_clk),
        .i_we      (w_wr),
        .i_waddr   (ADDR_W'(i_point_index)),
        .i_wdata   (w_wdata),
        .i_re      (w_rdy[0]),
        .i_raddr_a (w_sel.idx[0]),
        .i_raddr_b (w_sel.idx[1]),
        .o_rdata_a (w_rd[0]),
        .o_rdata_b (w_rd[1])
    );

    crpe_ram #(.WIDTH(2 * PT_W), .DEPTH(MAX_POINTS)) u_ram_hi (
        .i_clk     (i_clk),
        .i_we      (w_wr),
        .i_waddr   (ADDR_W'(i_point_index)),
        .i_wdata   (w_wdata),
        .i_re      (w_rdy[0]),
        .i_raddr_a (w_sel.idx[2]),
        .i_raddr_b (w_sel.idx[3]),
        .o_rdata_a (w_rd[2]),
        .o_rdata_b (w_rd[3])
    );

    // Stage 1: fraction and its square
    logic                 r1_err;
    logic [FRAC_BITS-1:0] r1_f;
    logic [F2_W-1:0]      r1_f2;

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r1_err <= w_sel.err;
            r1_f   <= w_f;
            r1_f2  <= F2_W'(w_f) * F2_W'(w_f);
        end
    end

    // Stage 2: cube, capture points
    logic                 r2_err;
    logic [FRAC_BITS-1:0] r2_f;
    logic [F2_W-1:0]      r2_f2;
    logic [F3_W-1:0]      r2_f3;
    logic signed [PT_W-1:0] r2_x [NUM_TAPS];
    logic signed [PT_W-1:0] r2_y [NUM_TAPS];

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r2_err <= r1_err;
            r2_f   <= r1_f;
            r2_f2  <= r1_f2;
            r2_f3  <= F3_W'(r1_f2) * F3_W'(r1_f);
            for (int i = 0; i < NUM_TAPS; i++) begin
                r2_x[i] <= w_rd[i][PT_W-1:0];
                r2_y[i] <= w_rd[i][2*PT_W-1:PT_W];
            end
        end
    end

    // Stage 3: weights in Q(3F), rounded to Q(2F)
    logic signed [Q_W-1:0] w_f3;
    logic signed [Q_W-1:0] w_tt;
    logic signed [Q_W-1:0] w_t1;
    logic signed [Q_W-1:0] w_q [NUM_TAPS];
    logic signed [Q_W-1:0] w_qr [NUM_TAPS];

    assign w_f3 = Q_W'(r2_f3);
    assign w_tt = Q_W'(r2_f2) << FRAC_BITS;
    assign w_t1 = Q_W'(r2_f) << (2 * FRAC_BITS);

    assign w_q[0] = (w_tt <<< 1) - w_f3 - w_t1;
    assign w_q[1] = (w_f3 <<< 1) + w_f3 + (ONE_Q <<< 1) - (w_tt <<< 2) - w_tt;
    assign w_q[2] = (w_tt <<< 2) + w_t1 - (w_f3 <<< 1) - w_f3;
    assign w_q[3] = w_f3 - w_tt;

    logic                   r3_err;
    logic signed [W_W-1:0]  r3_w [NUM_TAPS];
    logic signed [PT_W-1:0] r3_x [NUM_TAPS];
    logic signed [PT_W-1:0] r3_y [NUM_TAPS];

    always_comb begin
        for (int i = 0; i < NUM_TAPS; i++) begin
            w_qr[i] = w_q[i] + W_RND;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r3_err <= r2_err;
            for (int i = 0; i < NUM_TAPS; i++) begin
                r3_w[i] <= w_qr[i][FRAC_BITS +: W_W];
                r3_x[i] <= r2_x[i];
                r3_y[i] <= r2_y[i];
            end
        end
    end

    // Stage 4: weighted coordinates
    logic                     r4_err;
    logic signed [PROD_W-1:0] r4_px [NUM_TAPS];
    logic signed [PROD_W-1:0] r4_py [NUM_TAPS];
    logic signed [PROD_W-1:0] w_px [NUM_TAPS];
    logic signed [PROD_W-1:0] w_py [NUM_TAPS];

    always_comb begin
        for (int i = 0; i < NUM_TAPS; i++) begin
            w_px[i] = PROD_W'(r3_x[i]) * PROD_W'(r3_w[i]);
            w_py[i] = PROD_W'(r3_y[i]) * PROD_W'(r3_w[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[3]) begin
            r4_err <= r3_err;
            for (int i = 0; i < NUM_TAPS; i++) begin
                r4_px[i] <= w_px[i];
                r4_py[i] <= w_py[i];
            end
        end
    end

    // Stage 5: sum, round, saturate, zero on error
    logic signed [ACC_W-1:0] w_sx;
    logic signed [ACC_W-1:0] w_sy;
    logic signed [SUM_W-1:0] w_hx;
    logic signed [SUM_W-1:0] w_hy;
    logic signed [PT_W-1:0]  w_ox;
    logic signed [PT_W-1:0]  w_oy;

    assign w_sx = ACC_W'(r4_px[0]) + ACC_W'(r4_px[1]) + ACC_W'(r4_px[2])
                + ACC_W'(r4_px[3]) + OUT_RND;
    assign w_sy = ACC_W'(r4_py[0]) + ACC_W'(r4_py[1]) + ACC_W'(r4_py[2])
                + ACC_W'(r4_py[3]) + OUT_RND;
    assign w_hx = w_sx[ACC_W-1:OUT_SH];
    assign w_hy = w_sy[ACC_W-1:OUT_SH];

    always_comb begin
        priority if (w_hx > SAT_HI) begin
            w_ox = PT_W'(SAT_HI);
        end else if (w_hx < SAT_LO) begin
            w_ox = PT_W'(SAT_LO);
        end else begin
            w_ox = PT_W'(w_hx);
        end
        priority if (w_hy > SAT_HI) begin
            w_oy = PT_W'(SAT_HI);
        end else if (w_hy < SAT_LO) begin
            w_oy = PT_W'(SAT_LO);
        end else begin
            w_oy = PT_W'(w_hy);
        end
    end

    logic                   r5_err;
    logic signed [PT_W-1:0] r5_x;
    logic signed [PT_W-1:0] r5_y;

    always_ff @(posedge i_clk) begin
        if (w_rdy[4]) begin
            r5_err <= r4_err;
            r5_x   <= r4_err ? '0 : w_ox;
            r5_y   <= r4_err ? '0 : w_oy;
        end
    end

    assign o_out_valid   = r_v[N_STG-1];
    assign o_out_x       = r5_x;
    assign o_out_y       = r5_y;
    assign o_index_error = r5_err;

    // Checks
    `CRPE_ASSERT(a_err_gives_zero,
        (o_out_valid && o_index_error) |-> (o_out_x == '0 && o_out_y == '0))
    `CRPE_ASSERT(a_write_no_result,
        (i_in_valid && o_in_ready && i_cmd == CMD_WRITE) |=> !r_v[0])
    `CRPE_ASSERT(a_full_stall_blocks,
        ((&r_v) && !i_out_ready) |-> !o_in_ready)
    `CRPE_ASSERT_RST(a_reset_empties,
        !i_rst_n |=> (r_v == '0))

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import crpe_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = N_STG + 3;
    localparam int IDLE_PCT    = 35;
    localparam int GAP_PCT     = 20;
    localparam int REPORT_MAX  = 10;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 67;

    typedef struct {
        logic signed [PT_W-1:0] x;
        logic signed [PT_W-1:0] y;
        logic                   err;
    } t_blend;

    // Shadow of the point store and registers, plus the queue of pending blends
    class point_eval_board;
        logic [2*PT_W-1:0] points [MAX_POINTS];
        logic              looped;
        logic [CNT_W-1:0]  count;
        t_blend            expected_blends [$];
        int                failures;

        function new();
            looped   = 1'b0;
            count    = COUNT_RESET;
            failures = 0;
        endfunction

        // Saturate a rounded sum to the signed Q8.8 output range
        function logic signed [PT_W-1:0] clamp16(longint v);
            if (v > longint'(2 ** (PT_W - 1) - 1))
                return {1'b0, {(PT_W-1){1'b1}}};
            if (v < -longint'(2 ** (PT_W - 1)))
                return {1'b1, {(PT_W-1){1'b0}}};
            return v[PT_W-1:0];
        endfunction

        // Note one accepted transaction: store a point or queue its blend
        function void accept_item(logic cmd, logic [PIDX_W-1:0] pidx, logic [PT_W-1:0] px,
                                  logic [PT_W-1:0] py, logic [T_W-1:0] t);
            int          n;
            int          seg;
            int          taps [NUM_TAPS];
            longint      f, f2, f3, w, acc_x, acc_y;
            longint      wq [NUM_TAPS];
            logic [2*PT_W-1:0] p;
            t_blend      b;

            if (cmd == CMD_WRITE) begin
                points[pidx] = {py, px};
                return;
            end

            n     = (count > MAX_POINTS) ? MAX_POINTS : int'(count);
            seg   = int'(t >> FRAC_BITS);
            f     = longint'(t[FRAC_BITS-1:0]);
            b.err = (n == 0);

            // pick the four neighbors for the active index mode
            if (!b.err) begin
                if (looped) begin
                    for (int i = 0; i < NUM_TAPS; i++)
                        taps[i] = seg + i;
                end else begin
                    taps[1] = seg;
                    taps[0] = (seg >= 1) ? seg - 1 : 0;
                    taps[2] = (seg + 1) % n;
                    taps[3] = (taps[2] == n - 1) ? taps[2] : (taps[2] + 1) % n;
                end
                for (int i = 0; i < NUM_TAPS; i++)
                    if (taps[i] >= n)
                        b.err = 1'b1;
            end

            if (b.err) begin
                b.x = '0;
                b.y = '0;
                expected_blends = {expected_blends, b};
                return;
            end

            // form the weights exactly in Q(3F)
            f2    = f * f;
            f3    = f2 * f;
            wq[0] = -f3 + 2 * (f2 <<< FRAC_BITS) - (f <<< F2_W);
            wq[1] = 3 * f3 + 2 * (longint'(1) <<< F3_W) - 5 * (f2 <<< FRAC_BITS);
            wq[2] = 4 * (f2 <<< FRAC_BITS) + (f <<< F2_W) - 3 * f3;
            wq[3] = f3 - (f2 <<< FRAC_BITS);

            // round weights to Q(2F) and accumulate exact products
            acc_x = 0;
            acc_y = 0;
            for (int i = 0; i < NUM_TAPS; i++) begin
                p     = points[taps[i] % MAX_POINTS];
                w     = (wq[i] + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
                acc_x += longint'($signed(p[PT_W-1:0])) * w;
                acc_y += longint'($signed(p[2*PT_W-1:PT_W])) * w;
            end

            b.x = clamp16((acc_x + (longint'(1) <<< F2_W)) >>> OUT_SH);
            b.y = clamp16((acc_y + (longint'(1) <<< F2_W)) >>> OUT_SH);
            expected_blends = {expected_blends, b};
        endfunction

        // Compare one accepted result with the oldest pending blend
        function void check_result(logic signed [PT_W-1:0] x, logic signed [PT_W-1:0] y,
                                   logic err);
            t_blend b;

            if (expected_blends.size() == 0) begin
                if (failures < REPORT_MAX)
                    $display("unexpected result: x=%0d y=%0d err=%0b", x, y, err);
                failures++;
                return;
            end
            b = expected_blends.pop_front();
            if (x !== b.x || y !== b.y || err !== b.err) begin
                if (failures < REPORT_MAX)
                    $display("mismatch: expected x=%0d y=%0d err=%0b, got x=%0d y=%0d err=%0b",
                             b.x, b.y, b.err, x, y, err);
                failures++;
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic                   i_cmd;
    logic [PIDX_W-1:0]      i_point_index;
    logic signed [PT_W-1:0] i_point_x;
    logic signed [PT_W-1:0] i_point_y;
    logic [T_W-1:0]         i_t_param;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic signed [PT_W-1:0] o_out_x;
    logic signed [PT_W-1:0] o_out_y;
    logic                   o_index_error;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [PDATA_W-1:0]     pwdata;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    bit              idle_on = 1'b1;
    int unsigned     cycle_count = 0;
    point_eval_board board = new();

    catmull_rom_point_eval dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Stall the result side at random while idling is enabled
    always @(posedge i_clk) begin
        i_out_ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
    end

    // Watch both channels and feed the board
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                board.accept_item(i_cmd, i_point_index, i_point_x, i_point_y, i_t_param);
            if (o_out_valid && i_out_ready)
                board.check_result(o_out_x, o_out_y, o_index_error);
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Present one transaction, hold it until accepted, then maybe idle
    task automatic send_item(logic cmd, logic [PIDX_W-1:0] pidx, logic [PT_W-1:0] px,
                             logic [PT_W-1:0] py, logic [T_W-1:0] t);
        i_in_valid    <= 1'b1;
        i_cmd         <= cmd;
        i_point_index <= pidx;
        i_point_x     <= px;
        i_point_y     <= py;
        i_t_param     <= t;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (idle_on && $urandom_range(99) < GAP_PCT) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic put_point(int idx, int x, int y);
        send_item(CMD_WRITE, PIDX_W'(idx), PT_W'(x), PT_W'(y), T_W'($urandom));
    endtask

    task automatic eval_at(int seg, int frac);
        send_item(CMD_EVAL, PIDX_W'($urandom), PT_W'($urandom), PT_W'($urandom),
                  {SEG_W'(seg), FRAC_BITS'(frac)});
    endtask

    // Drop valid and wait out every pending blend plus the pipeline depth
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (board.expected_blends.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Setup and access cycle on the register port, then mirror the value
    task automatic reg_write(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx) << 2;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_LOOPED_MODE)
            board.looped = data[0];
        else
            board.count = data[CNT_W-1:0];
    endtask

    initial begin
        bit                   phase_looped [PHASES];
        int                   phase_count [PHASES];
        int                   n;
        int                   top_seg;
        bit                   any_valid;
        logic [SEG_W-1:0]     seg;
        logic [FRAC_BITS-1:0] frac;

        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_cmd         <= CMD_WRITE;
        i_point_index <= '0;
        i_point_x     <= '0;
        i_point_y     <= '0;
        i_t_param     <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill the whole store so no evaluation ever reads an unwritten entry
        for (int i = 0; i < MAX_POINTS; i++)
            put_point(i, $urandom, $urandom);
        wait_drained();

        // saturation both ways, fraction extremes, clamp and wrap of the ends
        reg_write(REG_LOOPED_MODE, 0);
        reg_write(REG_POINT_COUNT, MAX_POINTS);
        put_point(10, 16'h8000, 16'h8000);
        put_point(11, 16'h7fff, 16'h7fff);
        put_point(12, 16'h7fff, 16'h7fff);
        put_point(13, 16'h8000, 16'h8000);
        eval_at(11, 2048);
        eval_at(11, 0);
        eval_at(11, 4095);
        put_point(20, 16'h7fff, 16'h7fff);
        put_point(21, 16'h8000, 16'h8000);
        put_point(22, 16'h8000, 16'h8000);
        put_point(23, 16'h7fff, 16'h7fff);
        eval_at(21, 2048);
        eval_at(0, 1000);
        eval_at(62, 3000);
        eval_at(63, 2048);
        wait_drained();

        // short store: out of range, wrap of p2, repeat of the last point
        reg_write(REG_POINT_COUNT, 4);
        eval_at(5, 0);
        eval_at(3, 100);
        eval_at(2, 777);
        wait_drained();

        // offset mode at the top of the store
        reg_write(REG_LOOPED_MODE, 1);
        reg_write(REG_POINT_COUNT, MAX_POINTS);
        eval_at(60, 4095);
        eval_at(61, 0);
        wait_drained();

        // zero count, then a count past the store
        reg_write(REG_POINT_COUNT, 0);
        eval_at(0, 0);
        wait_drained();
        reg_write(REG_LOOPED_MODE, 0);
        reg_write(REG_POINT_COUNT, 127);
        eval_at(63, 2048);
        wait_drained();

        // random phases over a spread of modes and counts
        phase_looped = '{0, 1, 0, 1, 0, 1, 0, 1, 0, 1};
        phase_count  = '{2, 4, 64, 64, 1, 0, 0, 3, 0, 127};
        phase_count[5] = $urandom_range(5, 63);
        phase_count[6] = $urandom_range(3, 63);
        phase_count[8] = $urandom_range(65, 127);
        for (int p = 0; p < PHASES; p++) begin
            // one phase runs with no idling on either side
            idle_on = (p != 2);
            reg_write(REG_LOOPED_MODE, phase_looped[p]);
            reg_write(REG_POINT_COUNT, phase_count[p]);
            n         = (phase_count[p] > MAX_POINTS) ? MAX_POINTS : phase_count[p];
            any_valid = phase_looped[p] ? (n >= NUM_TAPS) : (n >= 1);
            top_seg   = phase_looped[p] ? n - NUM_TAPS : n - 1;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(99) < 25) begin
                    put_point($urandom_range(MAX_POINTS - 1), $urandom, $urandom);
                end else begin
                    // mostly in-range segments, some anywhere to hit the error path
                    if (any_valid && $urandom_range(99) >= 15)
                        seg = SEG_W'($urandom_range(top_seg));
                    else
                        seg = SEG_W'($urandom);
                    case ($urandom_range(9))
                        0:       frac = '0;
                        1:       frac = '1;
                        default: frac = FRAC_BITS'($urandom);
                    endcase
                    eval_at(seg, frac);
                end
            end
            wait_drained();
        end

        // anything still queued never arrived
        board.failures += board.expected_blends.size();
        if (board.failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
